// File: src/neighbor_mean_3x3_filter_top_macros.svh
// Assertion helpers used by the filter's back end (nmf_back).
`ifndef NEIGHBOR_MEAN_3X3_FILTER_TOP_MACROS_SVH
`define NEIGHBOR_MEAN_3X3_FILTER_TOP_MACROS_SVH

// Same-cycle implication under reset.
`define NMF_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmf: same-cycle check failed");

// Next-cycle implication under reset.
`define NMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmf: next-cycle check failed");

`endif

// File: src/nmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared types, constants and helpers of the 3x3 neighbour mean filter.
// ----------------------------------------------------------------------------
package nmf_pkg;

    localparam int ROW_BITS       = 10;
    localparam int OUT_COL_BITS   = 5;
    localparam int MEAN_BITS      = 16;
    localparam int PIXEL_IN_BITS  = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int FW_BITS        = 6;
    localparam int FH_BITS        = 11;
    localparam int CNT_BITS       = 4;

    localparam logic [FW_BITS-1:0] FW_RESET  = 6'd5;
    localparam logic [FH_BITS-1:0] FH_RESET  = 11'd5;
    localparam logic [FH_BITS-1:0] ROW_LIMIT = 11'd1024;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // neighbour offset codes
    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
        logic last;
        logic done;
    } nmf_flags_t;

    localparam int FLAG_BITS = $bits(nmf_flags_t);

    typedef struct packed {
        logic [1:0] dr;
        logic [1:0] dc;
    } nmf_pos_t;

    function automatic logic [1:0] rmod_dec(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : 2'(m - 2'd1);
    endfunction

    function automatic logic [1:0] rmod_inc(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : 2'(m + 2'd1);
    endfunction

    // in-frame neighbour count: 3, 5 or 8
    function automatic logic [CNT_BITS-1:0] nb_count(input nmf_flags_t f);
        logic [CNT_BITS-1:0] nr;
        logic [CNT_BITS-1:0] nc;
        nr = CNT_BITS'(1) + CNT_BITS'(f.up) + CNT_BITS'(f.down);
        nc = CNT_BITS'(1) + CNT_BITS'(f.left) + CNT_BITS'(f.right);
        return CNT_BITS'(nr * nc) - CNT_BITS'(1);
    endfunction

    // raster walk over the 3x3 window, step 4 is the centre
    function automatic nmf_pos_t nb_pos(input logic [3:0] k);
        nmf_pos_t p;
        unique case (k)
            4'd0:    p = '{OFS_MINUS, OFS_MINUS};
            4'd1:    p = '{OFS_MINUS, OFS_ZERO};
            4'd2:    p = '{OFS_MINUS, OFS_PLUS};
            4'd3:    p = '{OFS_ZERO,  OFS_MINUS};
            4'd5:    p = '{OFS_ZERO,  OFS_PLUS};
            4'd6:    p = '{OFS_PLUS,  OFS_MINUS};
            4'd7:    p = '{OFS_PLUS,  OFS_ZERO};
            4'd8:    p = '{OFS_PLUS,  OFS_PLUS};
            default: p = '{OFS_ZERO,  OFS_ZERO};
        endcase
        return p;
    endfunction

endpackage

// File: src/nmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/nmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_front
// Config registers, raster position, line store write and job generation.
// ----------------------------------------------------------------------------
module nmf_front #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 8,
    parameter int CW         = 5,
    parameter int AW         = 7,
    parameter int JW         = 23
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [nmf_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [nmf_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                    push,
    input  logic [nmf_pkg::PIXEL_IN_BITS-1:0]       pixel,
    output logic                                    full,
    input  logic                                    drained,
    input  logic                                    q_space,
    output logic                                    ram_we,
    output logic [AW-1:0]                           ram_waddr,
    output logic [PIXEL_BITS-1:0]                   ram_wdata,
    output logic [3:0]                              job_valid,
    output logic [3:0][JW-1:0]                      job_data
);

    localparam int EW = (CW + 1 > nmf_pkg::FW_BITS) ? CW + 1 : nmf_pkg::FW_BITS;

    logic [nmf_pkg::FW_BITS-1:0]  width_reg;
    logic [nmf_pkg::FH_BITS-1:0]  height_reg;
    logic [CW-1:0]                col_reg;
    logic [nmf_pkg::ROW_BITS-1:0] row_reg;
    logic [1:0]                   rmod_reg;

    logic [EW-1:0]                w_ext;
    logic [EW-1:0]                w_eff;
    logic [nmf_pkg::FH_BITS-1:0]  h_eff;
    logic [CW-1:0]                last_col;
    logic [nmf_pkg::ROW_BITS-1:0] last_row;
    logic                         accept;
    logic                         at_rend;
    logic                         at_flast;
    logic [AW-1:0]                base;
    logic [3:0]                   jv;

    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(2))
            w_eff = EW'(2);
        else if (w_ext > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (height_reg < 11'd2)
            h_eff = 11'd2;
        else if (height_reg > nmf_pkg::ROW_LIMIT)
            h_eff = nmf_pkg::ROW_LIMIT;
        else
            h_eff = height_reg;
    end

    assign last_col = CW'(w_eff - EW'(1));
    assign last_row = nmf_pkg::ROW_BITS'(h_eff - 11'd1);

    // a new row may only start once all older jobs have read the store
    assign full   = !q_space || ((col_reg == '0) && !drained);
    assign accept = push && !full;

    assign at_rend  = (col_reg == last_col);
    assign at_flast = (row_reg == last_row);

    always_comb
    begin
        unique case (rmod_reg)
            2'd0:    base = '0;
            2'd1:    base = AW'(MAX_WIDTH);
            default: base = AW'(2 * MAX_WIDTH);
        endcase
    end

    assign ram_we    = accept;
    assign ram_waddr = base + AW'(col_reg);
    assign ram_wdata = PIXEL_BITS'(pixel);

    function automatic logic [JW-1:0] pack_job(
        input logic [nmf_pkg::ROW_BITS-1:0] r,
        input logic [CW-1:0]                c,
        input logic [1:0]                   m,
        input logic [nmf_pkg::ROW_BITS-1:0] lr,
        input logic [CW-1:0]                lc,
        input logic                         lst
    );
        nmf_pkg::nmf_flags_t f;
        f.up    = (r != '0);
        f.down  = (r != lr);
        f.left  = (c != '0);
        f.right = (c != lc);
        f.last  = lst;
        f.done  = (r == lr) && (c == lc);
        return {r, c, m, f};
    endfunction

    always_comb
    begin
        jv[0] = (row_reg != '0) && (col_reg != '0);
        jv[1] = (row_reg != '0) && at_rend;
        jv[2] = at_flast && (col_reg != '0);
        jv[3] = at_flast && at_rend;
        job_valid = accept ? jv : 4'b0000;
        job_data[0] = pack_job(row_reg - 1'b1, col_reg - 1'b1,
                               nmf_pkg::rmod_dec(rmod_reg), last_row, last_col,
                               jv[3:1] == 3'b000);
        job_data[1] = pack_job(row_reg - 1'b1, col_reg,
                               nmf_pkg::rmod_dec(rmod_reg), last_row, last_col,
                               jv[3:2] == 2'b00);
        job_data[2] = pack_job(row_reg, col_reg - 1'b1, rmod_reg, last_row, last_col,
                               !jv[3]);
        job_data[3] = pack_job(row_reg, col_reg, rmod_reg, last_row, last_col, 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nmf_pkg::FW_RESET;
            height_reg <= nmf_pkg::FH_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            rmod_reg   <= 2'd0;
        end
        else if (cfg_we &&
                 (cfg_index == nmf_pkg::CFG_FRAME_WIDTH ||
                  cfg_index == nmf_pkg::CFG_FRAME_HEIGHT))
        begin
            if (cfg_index == nmf_pkg::CFG_FRAME_WIDTH)
                width_reg <= nmf_pkg::FW_BITS'(cfg_data);
            else
                height_reg <= cfg_data;
            col_reg  <= '0;
            row_reg  <= '0;
            rmod_reg <= 2'd0;
        end
        else if (accept)
        begin
            if (at_rend)
            begin
                col_reg <= '0;
                if (at_flast)
                begin
                    row_reg  <= '0;
                    rmod_reg <= 2'd0;
                end
                else
                begin
                    row_reg  <= row_reg + 1'b1;
                    rmod_reg <= nmf_pkg::rmod_inc(rmod_reg);
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

endmodule

// File: src/nmf_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_jobq
// Eight-deep job queue, up to four pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module nmf_jobq #(
    parameter int JW = 23
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           push_valid,
    input  logic [3:0][JW-1:0]   push_data,
    input  logic                 pop,
    output logic [JW-1:0]        rd_data,
    output logic                 empty,
    output logic                 space4
);

    localparam int DEPTH = 8;
    localparam int PW    = $clog2(DEPTH);

    logic [JW-1:0]   mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [3:0][PW-1:0] slot_ofs;
    logic [PW:0]     n_push;

    always_comb
    begin
        slot_ofs[0] = '0;
        for (int i = 1; i < 4; i++)
            slot_ofs[i] = slot_ofs[i-1] + PW'(push_valid[i-1]);
        n_push = (PW+1)'($countones(push_valid));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (push_valid[i])
                mem[PW'(wr_ptr_reg + slot_ofs[i])] <= push_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(n_push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + n_push - (PW+1)'(pop);
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign space4  = (count_reg <= (PW+1)'(DEPTH - 4));

endmodule

// File: src/nmf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_back
// Gathers a job's neighbours from the line store, divides, holds the word.
// ----------------------------------------------------------------------------
`include "neighbor_mean_3x3_filter_top_macros.svh"

module nmf_back #(
    parameter int MAX_WIDTH     = 32,
    parameter int PIXEL_BITS    = 8,
    parameter int FRACTION_BITS = 8,
    parameter int CW            = 5,
    parameter int AW            = 7,
    parameter int JW            = 23
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [JW-1:0]                         job_data,
    input  logic                                  job_empty,
    output logic                                  job_pop,
    output logic                                  idle,
    output logic [AW-1:0]                         ram_raddr,
    input  logic [PIXEL_BITS-1:0]                 ram_rdata,
    input  logic                                  pop,
    output logic                                  empty,
    output logic [nmf_pkg::MEAN_BITS-1:0]         mean_q8,
    output logic [nmf_pkg::ROW_BITS-1:0]          out_row,
    output logic [nmf_pkg::OUT_COL_BITS-1:0]      out_col,
    output logic                                  last_of_run,
    output logic                                  frame_done
);

    localparam int SW  = PIXEL_BITS + 3;
    localparam int DW  = SW + FRACTION_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam int FB  = nmf_pkg::FLAG_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_GATHER = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_WAIT   = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [JW-1:0]                 job_reg;
    logic [3:0]                    step_reg, step_next;
    logic                          rdv_reg, rdv_next;
    logic [SW-1:0]                 acc_reg, acc_next;
    logic [3:0]                    rem_reg, rem_next;
    logic [DW-1:0]                 dq_reg, dq_next;
    logic [DCW-1:0]                dcnt_reg, dcnt_next;
    logic [nmf_pkg::CNT_BITS-1:0]  cnt_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [nmf_pkg::MEAN_BITS-1:0] mean_reg;
    logic [nmf_pkg::ROW_BITS-1:0]  orow_reg;
    logic [nmf_pkg::OUT_COL_BITS-1:0] ocol_reg;
    logic                          olast_reg;
    logic                          odone_reg;

    logic [nmf_pkg::ROW_BITS-1:0]  j_row;
    logic [CW-1:0]                 j_col;
    logic [1:0]                    j_rmod;
    nmf_pkg::nmf_flags_t           j_flags;
    nmf_pkg::nmf_pos_t             pos;
    logic                          pos_ok;
    logic [1:0]                    rd_rmod;
    logic [CW-1:0]                 rd_col;
    logic [AW-1:0]                 rd_base;
    logic [SW-1:0]                 acc_sum;
    logic [4:0]                    trial;
    logic                          ge;
    logic                          out_load;

    assign j_row   = job_reg[JW-1 -: nmf_pkg::ROW_BITS];
    assign j_col   = job_reg[FB + 2 +: CW];
    assign j_rmod  = job_reg[FB +: 2];
    assign j_flags = nmf_pkg::nmf_flags_t'(job_reg[FB-1:0]);

    // address of the window position under the step counter
    always_comb
    begin
        pos = nmf_pkg::nb_pos(step_reg);
        pos_ok = 1'b1;
        rd_rmod = j_rmod;
        rd_col  = j_col;
        unique case (pos.dr)
            nmf_pkg::OFS_MINUS: begin pos_ok = j_flags.up;
                                      rd_rmod = nmf_pkg::rmod_dec(j_rmod); end
            nmf_pkg::OFS_PLUS:  begin pos_ok = j_flags.down;
                                      rd_rmod = nmf_pkg::rmod_inc(j_rmod); end
            default: ;
        endcase
        unique case (pos.dc)
            nmf_pkg::OFS_MINUS: begin pos_ok = pos_ok && j_flags.left;
                                      rd_col = j_col - 1'b1; end
            nmf_pkg::OFS_PLUS:  begin pos_ok = pos_ok && j_flags.right;
                                      rd_col = j_col + 1'b1; end
            default: ;
        endcase
        if (pos.dr == nmf_pkg::OFS_ZERO && pos.dc == nmf_pkg::OFS_ZERO)
            pos_ok = 1'b0;
        unique case (rd_rmod)
            2'd0:    rd_base = '0;
            2'd1:    rd_base = AW'(MAX_WIDTH);
            default: rd_base = AW'(2 * MAX_WIDTH);
        endcase
    end

    assign ram_raddr = rd_base + AW'(rd_col);
    assign acc_sum   = acc_reg + (rdv_reg ? SW'(ram_rdata) : SW'(0));

    assign trial = {rem_reg, dq_reg[DW-1]};
    assign ge    = (trial >= {1'b0, cnt_reg});

    assign idle     = (state_reg == ST_IDLE);
    assign job_pop  = idle && !job_empty;
    assign out_load = (state_reg == ST_WAIT) && (!out_valid_reg || pop);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rdv_next       = 1'b0;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = ST_GATHER;
                    step_next  = 4'd0;
                    acc_next   = '0;
                end
            end
            ST_GATHER:
            begin
                acc_next  = acc_sum;
                rdv_next  = (step_reg < 4'd9) && pos_ok;
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd9)
                begin
                    state_next = ST_DIVIDE;
                    rem_next   = 4'd0;
                    dq_next    = DW'(acc_sum) << FRACTION_BITS;
                    dcnt_next  = DCW'(DW);
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = ge ? 4'(trial - {1'b0, cnt_reg}) : trial[3:0];
                dq_next   = {dq_reg[DW-2:0], ge};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCW'(1))
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rdv_reg       <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        dcnt_reg <= dcnt_next;
        if (job_pop)
        begin
            job_reg <= job_data;
            cnt_reg <= nmf_pkg::nb_count(nmf_pkg::nmf_flags_t'(job_data[FB-1:0]));
        end
        if (out_load)
        begin
            mean_reg  <= nmf_pkg::MEAN_BITS'(dq_reg);
            orow_reg  <= j_row;
            ocol_reg  <= nmf_pkg::OUT_COL_BITS'(j_col);
            olast_reg <= j_flags.last;
            odone_reg <= j_flags.done;
        end
    end

    assign empty       = !out_valid_reg;
    assign mean_q8     = mean_reg;
    assign out_row     = orow_reg;
    assign out_col     = ocol_reg;
    assign last_of_run = olast_reg;
    assign frame_done  = odone_reg;

    `NMF_ASSERT_HOLDS(a_div_count, clk, rst_n, state_reg == ST_DIVIDE, cnt_reg == 4'd3 || cnt_reg == 4'd5 || cnt_reg == 4'd8)
    `NMF_ASSERT_HOLDS(a_gather_step, clk, rst_n, state_reg == ST_GATHER, step_reg <= 4'd9)
    `NMF_ASSERT_NEXT(a_job_taken, clk, rst_n, job_pop, state_reg == ST_GATHER)

endmodule

// File: src/neighbor_mean_3x3_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_mean_3x3_filter_top
// Streaming 3x3 neighbour mean (centre excluded) over a raster pixel stream.
// ----------------------------------------------------------------------------
//
//  channel   handshake          word
//  -------   ----------------   ------------------------------------------
//  config    cfg_we             cfg_index, cfg_data (0 width, 1 height)
//  pixels    push / full        pixel
//  results   pop / empty        mean_q8, out_row, out_col, last_of_run,
//                               frame_done
//
//  A pixel is taken while full is low; it is written to the line store and its
//  completed targets (0 to 4) enter an eight-deep job queue.
//  In the back end each result takes a walk over the nine window positions,
//  using the single read port, then a bit-serial divide by the neighbour count.
//  full rises while the queue lacks room for four jobs, and at the first
//  pixel of every row until all older jobs are done, so a row never
//  overwrites store contents still being read.
//  Reset is asynchronous; the line store needs no clearing pass.
//  Results wait in an output register, so a stalled pop only holds the back.
//
module neighbor_mean_3x3_filter_top #(
    parameter int MAX_WIDTH     = 32,
    parameter int PIXEL_BITS    = 8,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [nmf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [nmf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic [nmf_pkg::PIXEL_IN_BITS-1:0]     pixel,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [nmf_pkg::MEAN_BITS-1:0]         mean_q8,
    output logic [nmf_pkg::ROW_BITS-1:0]          out_row,
    output logic [nmf_pkg::OUT_COL_BITS-1:0]      out_col,
    output logic                                  last_of_run,
    output logic                                  frame_done
);

    // column index, store address and packed job widths
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = nmf_pkg::ROW_BITS + CW + 2 + nmf_pkg::FLAG_BITS;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [PIXEL_BITS-1:0]  ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [PIXEL_BITS-1:0]  ram_rdata;
    logic [3:0]             job_valid;
    logic [3:0][JW-1:0]     job_data;
    logic [JW-1:0]          q_data;
    logic                   q_empty;
    logic                   q_space;
    logic                   q_pop;
    logic                   back_idle;
    logic                   drained;

    // nothing queued and nothing in flight in the back end
    assign drained = q_empty && back_idle;

    nmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .AW         (AW),
        .JW         (JW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .pixel     (pixel),
        .full      (full),
        .drained   (drained),
        .q_space   (q_space),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .job_valid (job_valid),
        .job_data  (job_data)
    );

    // three rows of pixels, row r held in bank r mod 3
    nmf_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nmf_jobq #(
        .JW (JW)
    ) u_jobq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_data  (job_data),
        .pop        (q_pop),
        .rd_data    (q_data),
        .empty      (q_empty),
        .space4     (q_space)
    );

    nmf_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PIXEL_BITS    (PIXEL_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .CW            (CW),
        .AW            (AW),
        .JW            (JW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_data    (q_data),
        .job_empty   (q_empty),
        .job_pop     (q_pop),
        .idle        (back_idle),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .pop         (pop),
        .empty       (empty),
        .mean_q8     (mean_q8),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

endmodule
